/* design/rdf_pkg.sv */
package rdf_pkg;

  localparam int RING_ENTRIES_DEF = 32;
  localparam int KEY_W = 256;
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam logic [15:0] HEADER_BYTES = 16'd5;
  localparam logic [15:0] MAX_LENGTH_RESET = 16'd1024;

  // Register indexes, taken from paddr[3:2].
  localparam logic [1:0] REG_NOSPAM_WORD = 2'd0;
  localparam logic [1:0] REG_HANDLER_ENABLED = 2'd1;
  localparam logic [1:0] REG_MAX_LENGTH = 2'd2;

  typedef enum logic [2:0] {
    ST_ACCEPTED     = 3'd0,
    ST_BAD_LENGTH   = 3'd1,
    ST_NO_HANDLER   = 3'd2,
    ST_DUPLICATE    = 3'd3,
    ST_SPAM         = 3'd4,
    ST_FILTERED     = 3'd5,
    ST_REMOVED      = 3'd6,
    ST_NOT_FOUND    = 3'd7
  } status_t;

  typedef struct packed {
    logic        func;
    logic [63:0] key_word0;
    logic [63:0] key_word1;
    logic [63:0] key_word2;
    logic [63:0] key_word3;
    logic [15:0] packet_length;
    logic [31:0] nospam_value;
    logic        filter_rejects;
  } req_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] message_length;
  } rsp_t;

  typedef struct packed {
    logic [31:0] nospam_word;
    logic        handler_enabled;
    logic [15:0] max_length;
  } cfg_t;

  // Search token that walks the chain, one cell per cycle.
  typedef struct packed {
    logic valid;
    logic found;
  } tok_t;

endpackage

/* design/request_dedup_filter.sv */
// Channel   Direction  Handshake                    Payload
// req       in         req_valid / req_ready        req (rdf_pkg::req_t)
// rsp       out        rsp_valid / rsp_ready        rsp (rdf_pkg::rsp_t)
// apb       in/out     psel, penable, pwrite, pready paddr, pwdata, prdata
//
// One transaction at a time: a search token walks the chain of RING_ENTRIES
// key cells, one cell per clock, and the next request is taken only once the
// response has been issued and the block is back in its idle state.
// Reset is synchronous; the ring reads as all-zero keys right after it.
// A stalled response holds the block in its final step and blocks new requests.
module request_dedup_filter #(
  parameter int RING_ENTRIES = rdf_pkg::RING_ENTRIES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_ready,
  input  rdf_pkg::req_t               req,
  output logic                        rsp_valid,
  input  logic                        rsp_ready,
  output rdf_pkg::rsp_t               rsp,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rdf_pkg::PADDR_W-1:0] paddr,
  input  logic [rdf_pkg::PDATA_W-1:0] pwdata,
  output logic [rdf_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);
  import rdf_pkg::*;

  localparam int IDX_W = $clog2(RING_ENTRIES);

  typedef enum logic [1:0] {
    IDLE,
    SEARCH,
    FINISH
  } state_t;

  state_t           state;
  req_t             item;
  logic             start;
  logic             found;
  logic [IDX_W-1:0] write_index;
  cfg_t             cfg;
  tok_t             tok [RING_ENTRIES+1];
  logic [KEY_W-1:0] key;
  status_t          status;
  logic [15:0]      msg_len;
  logic             finish;
  logic             wr_en;

  rdf_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign key = {item.key_word3, item.key_word2, item.key_word1, item.key_word0};
  assign tok[0].valid = start;
  assign tok[0].found = 1'b0;

  for (genvar i = 0; i < RING_ENTRIES; i++) begin : g_cell
    rdf_cell #(
      .IDX_W    (IDX_W),
      .CELL_IDX (i)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .key     (key),
      .remove  (item.func),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1]),
      .wr_en   (wr_en),
      .wr_idx  (write_index)
    );
  end

  always_comb begin
    msg_len = '0;
    if (item.func) begin
      status = found ? ST_REMOVED : ST_NOT_FOUND;
    end else if (item.packet_length <= HEADER_BYTES ||
                 item.packet_length > cfg.max_length) begin
      status = ST_BAD_LENGTH;
    end else if (!cfg.handler_enabled) begin
      status = ST_NO_HANDLER;
    end else if (found) begin
      status = ST_DUPLICATE;
    end else if (item.nospam_value != cfg.nospam_word) begin
      status = ST_SPAM;
    end else if (item.filter_rejects) begin
      status = ST_FILTERED;
    end else begin
      status  = ST_ACCEPTED;
      msg_len = item.packet_length - HEADER_BYTES;
    end
  end

  assign req_ready = (state == IDLE);
  assign finish    = (state == FINISH) && (!rsp_valid || rsp_ready);
  assign wr_en     = finish && (status == ST_ACCEPTED);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= IDLE;
      start       <= 1'b0;
      found       <= 1'b0;
      write_index <= '0;
      rsp_valid   <= 1'b0;
    end else begin
      start <= (state == IDLE) && req_valid;
      if (rsp_valid && rsp_ready && !finish) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (req_valid) begin
            state <= SEARCH;
          end
        end
        SEARCH: begin
          if (tok[RING_ENTRIES].valid) begin
            found <= tok[RING_ENTRIES].found;
            state <= FINISH;
          end
        end
        FINISH: begin
          if (finish) begin
            rsp_valid <= 1'b1;
            state     <= IDLE;
            if (wr_en) begin
              if (write_index == IDX_W'(RING_ENTRIES - 1)) begin
                write_index <= '0;
              end else begin
                write_index <= write_index + 1'b1;
              end
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      item <= req;
    end
    if (finish) begin
      rsp.status         <= status;
      rsp.message_length <= msg_len;
    end
  end

endmodule

/* design/rdf_cell.sv */
module rdf_cell #(
  parameter int IDX_W = 5,
  parameter int CELL_IDX = 0
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [rdf_pkg::KEY_W-1:0] key,
  input  logic                      remove,
  input  rdf_pkg::tok_t             tok_in,
  output rdf_pkg::tok_t             tok_out,
  input  logic                      wr_en,
  input  logic [IDX_W-1:0]          wr_idx
);
  import rdf_pkg::*;

  logic [KEY_W-1:0] entry;
  logic             entry_valid;
  logic             match;
  logic             hit;

  // An entry that was never written, or was removed, reads as all zero.
  assign match = entry_valid ? (entry == key) : (key == '0);
  assign hit   = tok_in.valid & match;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= 1'b0;
      tok_out     <= '0;
    end else begin
      tok_out.valid <= tok_in.valid;
      tok_out.found <= tok_in.found | hit;
      if (wr_en && wr_idx == IDX_W'(CELL_IDX)) begin
        entry_valid <= 1'b1;
      end else if (hit && !tok_in.found && remove) begin
        entry_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && wr_idx == IDX_W'(CELL_IDX)) begin
      entry <= key;
    end
  end

endmodule

/* design/rdf_regs.sv */
module rdf_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rdf_pkg::PADDR_W-1:0] paddr,
  input  logic [rdf_pkg::PDATA_W-1:0] pwdata,
  output logic [rdf_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  output rdf_pkg::cfg_t               cfg
);
  import rdf_pkg::*;

  logic [1:0] reg_idx;
  logic       wr;

  assign reg_idx = paddr[PADDR_W-1:2];
  assign pready  = 1'b1;
  assign wr      = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.nospam_word     <= '0;
      cfg.handler_enabled <= 1'b0;
      cfg.max_length      <= MAX_LENGTH_RESET;
    end else if (wr) begin
      case (reg_idx)
        REG_NOSPAM_WORD:     cfg.nospam_word     <= pwdata;
        REG_HANDLER_ENABLED: cfg.handler_enabled <= pwdata[0];
        REG_MAX_LENGTH:      cfg.max_length      <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_NOSPAM_WORD:     prdata = cfg.nospam_word;
      REG_HANDLER_ENABLED: prdata = {{(PDATA_W-1){1'b0}}, cfg.handler_enabled};
      REG_MAX_LENGTH:      prdata = {{(PDATA_W-16){1'b0}}, cfg.max_length};
      default:             prdata = '0;
    endcase
  end

endmodule
